// ----- sv/pursuit_evade_steering_unit_assert.svh -----
// assertion macros shared by the steering unit modules
`ifndef PURSUIT_EVADE_STEERING_UNIT_ASSERT_SVH
`define PURSUIT_EVADE_STEERING_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PES_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pes: same-cycle check failed");

// next-cycle implication, checked outside reset
`define PES_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pes: next-cycle check failed");

`endif

// ----- sv/pes_pkg.sv -----
// types and constants of the pursuit/evade steering unit
`default_nettype none
package pes_pkg;

    typedef logic [1:0] arith_op_t;
    localparam arith_op_t OP_MUL  = 2'd0;
    localparam arith_op_t OP_DIV  = 2'd1;
    localparam arith_op_t OP_SQRT = 2'd2;

    typedef logic [4:0] step_t;
    localparam step_t STEP_NONE = 5'd0;
    localparam step_t STEP_RAWX = 5'd1;
    localparam step_t STEP_RAWY = 5'd2;
    localparam step_t STEP_DECX = 5'd3;
    localparam step_t STEP_DECY = 5'd4;
    localparam step_t STEP_BLX  = 5'd5;
    localparam step_t STEP_BLY  = 5'd6;
    localparam step_t STEP_SQX  = 5'd7;
    localparam step_t STEP_SQY  = 5'd8;
    localparam step_t STEP_DIST = 5'd9;
    localparam step_t STEP_TDIV = 5'd10;
    localparam step_t STEP_PX   = 5'd11;
    localparam step_t STEP_PY   = 5'd12;
    localparam step_t STEP_DX2  = 5'd13;
    localparam step_t STEP_DY2  = 5'd14;
    localparam step_t STEP_LEN  = 5'd15;
    localparam step_t STEP_UX   = 5'd16;
    localparam step_t STEP_UY   = 5'd17;

    localparam logic [15:0] DT_MIN_EXCL     = 16'd6;
    localparam logic [41:0] NEAR_ZERO_Q8    = 42'd256;
    localparam logic [33:0] DECAY_Q16       = 34'd62259;
    localparam logic [21:0] SPEED_MIN_EXCL  = 22'd256;
    localparam logic [17:0] CAP_PURSUIT_Q16 = 18'd196608;
    localparam logic [17:0] CAP_EVADE_Q16   = 18'd131072;

    typedef struct packed {
        logic  take;
        logic  go;
        logic  publish;
        step_t step;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic hist;
        logic dt_ok;
        logic near_zero;
        logic speed_ok;
        logic sum_zero;
        logic out_free;
        logic done;
    } sts_t;

endpackage
`default_nettype wire

// ----- sv/pes_if.sv -----
// input and result channels of the steering unit
`default_nettype none
interface pes_in_if;
    logic               valid;
    logic               ready;
    logic        [15:0] delta_t;
    logic signed [23:0] target_x;
    logic signed [23:0] target_y;
    logic signed [23:0] agent_x;
    logic signed [23:0] agent_y;
    logic        [21:0] agent_speed;

    modport source (output valid, delta_t, target_x, target_y, agent_x, agent_y,
                    agent_speed, input ready);
    modport sink (input valid, delta_t, target_x, target_y, agent_x, agent_y,
                  agent_speed, output ready);
endinterface

interface pes_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [23:0] predicted_x;
    logic signed [23:0] predicted_y;
    logic               primed;

    modport source (output valid, dir_x, dir_y, predicted_x, predicted_y, primed,
                    input ready);
    modport sink (input valid, dir_x, dir_y, predicted_x, predicted_y, primed,
                  output ready);
endinterface
`default_nettype wire

// ----- sv/pes_arith.sv -----
// shared bit-serial multiply, divide and square root unit
`default_nettype none
module pes_arith (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    go,
    input  pes_pkg::arith_op_t     op,
    input  wire             [65:0] a,
    input  wire             [33:0] b,
    output logic                   busy,
    output logic                   done,
    output logic            [66:0] result
);
    localparam int MUL_STEPS  = 25;
    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 33;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    pes_pkg::arith_op_t  op_reg, op_next;
    logic [6:0]          cnt_reg, cnt_next;
    logic [65:0]         x_reg, x_next;
    logic [33:0]         y_reg, y_next;
    logic [36:0]         r_reg, r_next;
    logic [66:0]         acc_reg, acc_next;

    logic [34:0]         div_sh;
    logic [36:0]         sq_sh;
    logic [36:0]         sq_trial;

    assign div_sh   = {r_reg[33:0], x_reg[63]};
    assign sq_sh    = {r_reg[34:0], x_reg[65:64]};
    assign sq_trial = {1'b0, y_reg, 2'b01};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        r_next    = r_reg;
        acc_next  = acc_reg;
        if (go)
        begin
            busy_next = 1'b1;
            op_next   = op;
            x_next    = a;
            y_next    = b;
            r_next    = '0;
            acc_next  = '0;
            unique case (op)
                pes_pkg::OP_MUL:  cnt_next = 7'(MUL_STEPS - 1);
                pes_pkg::OP_DIV:  cnt_next = 7'(DIV_STEPS - 1);
                pes_pkg::OP_SQRT: cnt_next = 7'(SQRT_STEPS - 1);
                default:          cnt_next = '0;
            endcase
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                pes_pkg::OP_MUL:
                begin
                    if (y_reg[0])
                        acc_next = acc_reg + {1'b0, x_reg};
                    x_next = {x_reg[64:0], 1'b0};
                    y_next = {1'b0, y_reg[33:1]};
                end
                pes_pkg::OP_DIV:
                begin
                    // restoring step, quotient shifts in behind the numerator
                    if (div_sh >= {1'b0, y_reg})
                    begin
                        r_next = 37'(div_sh - {1'b0, y_reg});
                        x_next = {x_reg[64:0], 1'b1};
                    end
                    else
                    begin
                        r_next = 37'(div_sh);
                        x_next = {x_reg[64:0], 1'b0};
                    end
                end
                pes_pkg::OP_SQRT:
                begin
                    x_next = {x_reg[63:0], 2'b00};
                    if (sq_sh >= sq_trial)
                    begin
                        r_next = sq_sh - sq_trial;
                        y_next = {y_reg[32:0], 1'b1};
                    end
                    else
                    begin
                        r_next = sq_sh;
                        y_next = {y_reg[32:0], 1'b0};
                    end
                end
                default:
                begin
                    x_next = x_reg;
                end
            endcase
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        r_reg   <= r_next;
        acc_reg <= acc_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;

    always_comb
    begin
        unique case (op_reg)
            pes_pkg::OP_MUL:  result = acc_reg;
            pes_pkg::OP_DIV:  result = {3'b000, x_reg[63:0]};
            pes_pkg::OP_SQRT: result = {33'd0, y_reg};
            default:          result = '0;
        endcase
    end
endmodule
`default_nettype wire

// ----- sv/pes_dpath.sv -----
// steering datapath: captured word, history, work registers, result register
`default_nettype none
module pes_dpath #(
    parameter int DIR_FRAC_BITS = 14
) (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             cfg_we,
    input  wire             cfg_wdata,
    pes_in_if.sink          req,
    pes_out_if.source       rsp,
    input  pes_pkg::cmd_t   cmd,
    output pes_pkg::sts_t   sts
);
    logic        [15:0] dt_reg;
    logic signed [23:0] tx_reg, ty_reg, ax_reg, ay_reg;
    logic        [21:0] spd_reg;

    logic               evade_reg;
    logic               hist_reg;
    logic signed [23:0] last_x_reg, last_y_reg;
    logic signed [31:0] vx_reg, vy_reg;
    logic               out_valid_reg;

    logic signed [41:0] rawx_reg, rawy_reg;
    logic        [49:0] sum_reg;
    logic        [25:0] dist_reg;
    logic        [17:0] t_reg;
    logic signed [23:0] px_reg, py_reg;
    logic        [33:0] len_reg;
    logic        [15:0] dirx_reg, diry_reg;
    logic               primed_reg;

    logic        [15:0] o_dirx_reg, o_diry_reg;
    logic signed [23:0] o_px_reg, o_py_reg;
    logic               o_primed_reg;

    logic               load;
    logic signed [24:0] mx, my, d0x, d0y, ddx, ddy;
    logic        [24:0] mx_mag, my_mag, d0x_mag, d0y_mag, ddx_mag, ddy_mag;
    logic        [31:0] vx_mag, vy_mag;
    logic signed [42:0] diffx, diffy;
    logic        [42:0] diffx_mag, diffy_mag;
    logic        [41:0] rawx_mag, rawy_mag;
    logic        [19:0] w10;
    logic        [17:0] cap;

    pes_pkg::arith_op_t arith_op;
    logic        [65:0] arith_a;
    logic        [33:0] arith_b;
    logic               arith_busy, arith_done;
    logic        [66:0] arith_res;

    logic signed [41:0] rawq;
    logic signed [31:0] dm;
    logic signed [46:0] bm, nvx, nvy;
    logic signed [34:0] pm, npx, npy;
    logic        [15:0] uq;

    function automatic logic signed [31:0] sat32(input logic signed [46:0] v);
        if (v > 47'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -47'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [34:0] v);
        if (v > 35'sd8388607)
            return 24'sh7fffff;
        else if (v < -35'sd8388608)
            return 24'sh800000;
        else
            return v[23:0];
    endfunction

    assign load = req.valid && cmd.take;

    assign mx  = 25'(tx_reg) - 25'(last_x_reg);
    assign my  = 25'(ty_reg) - 25'(last_y_reg);
    assign d0x = 25'(tx_reg) - 25'(ax_reg);
    assign d0y = 25'(ty_reg) - 25'(ay_reg);
    assign ddx = evade_reg ? 25'(ax_reg) - 25'(px_reg) : 25'(px_reg) - 25'(ax_reg);
    assign ddy = evade_reg ? 25'(ay_reg) - 25'(py_reg) : 25'(py_reg) - 25'(ay_reg);

    assign mx_mag  = mx[24]  ? 25'(-mx)  : 25'(mx);
    assign my_mag  = my[24]  ? 25'(-my)  : 25'(my);
    assign d0x_mag = d0x[24] ? 25'(-d0x) : 25'(d0x);
    assign d0y_mag = d0y[24] ? 25'(-d0y) : 25'(d0y);
    assign ddx_mag = ddx[24] ? 25'(-ddx) : 25'(ddx);
    assign ddy_mag = ddy[24] ? 25'(-ddy) : 25'(ddy);
    assign vx_mag  = vx_reg[31] ? 32'(-vx_reg) : 32'(vx_reg);
    assign vy_mag  = vy_reg[31] ? 32'(-vy_reg) : 32'(vy_reg);

    assign diffx     = 43'(rawx_reg) - 43'(vx_reg);
    assign diffy     = 43'(rawy_reg) - 43'(vy_reg);
    assign diffx_mag = diffx[42] ? 43'(-diffx) : 43'(diffx);
    assign diffy_mag = diffy[42] ? 43'(-diffy) : 43'(diffy);
    assign rawx_mag  = rawx_reg[41] ? 42'(-rawx_reg) : 42'(rawx_reg);
    assign rawy_mag  = rawy_reg[41] ? 42'(-rawy_reg) : 42'(rawy_reg);

    assign w10 = 20'(dt_reg) * 20'd10;
    assign cap = evade_reg ? pes_pkg::CAP_EVADE_Q16 : pes_pkg::CAP_PURSUIT_Q16;

    // operand select for the step the controller is running
    always_comb
    begin
        arith_op = pes_pkg::OP_MUL;
        arith_a  = '0;
        arith_b  = '0;
        unique case (cmd.step)
            pes_pkg::STEP_RAWX:
            begin
                arith_op = pes_pkg::OP_DIV;
                arith_a  = 66'(mx_mag) << 16;
                arith_b  = 34'(dt_reg);
            end
            pes_pkg::STEP_RAWY:
            begin
                arith_op = pes_pkg::OP_DIV;
                arith_a  = 66'(my_mag) << 16;
                arith_b  = 34'(dt_reg);
            end
            pes_pkg::STEP_DECX:
            begin
                arith_a = 66'(vx_mag);
                arith_b = pes_pkg::DECAY_Q16;
            end
            pes_pkg::STEP_DECY:
            begin
                arith_a = 66'(vy_mag);
                arith_b = pes_pkg::DECAY_Q16;
            end
            pes_pkg::STEP_BLX:
            begin
                arith_a = 66'(diffx_mag[41:0]);
                arith_b = 34'(w10);
            end
            pes_pkg::STEP_BLY:
            begin
                arith_a = 66'(diffy_mag[41:0]);
                arith_b = 34'(w10);
            end
            pes_pkg::STEP_SQX:
            begin
                arith_a = 66'(d0x_mag);
                arith_b = 34'(d0x_mag);
            end
            pes_pkg::STEP_SQY:
            begin
                arith_a = 66'(d0y_mag);
                arith_b = 34'(d0y_mag);
            end
            pes_pkg::STEP_DIST:
            begin
                arith_op = pes_pkg::OP_SQRT;
                arith_a  = 66'(sum_reg);
            end
            pes_pkg::STEP_TDIV:
            begin
                arith_op = pes_pkg::OP_DIV;
                arith_a  = 66'(dist_reg) << 16;
                arith_b  = 34'(spd_reg);
            end
            pes_pkg::STEP_PX:
            begin
                arith_a = 66'(vx_mag);
                arith_b = 34'(t_reg);
            end
            pes_pkg::STEP_PY:
            begin
                arith_a = 66'(vy_mag);
                arith_b = 34'(t_reg);
            end
            pes_pkg::STEP_DX2:
            begin
                arith_a = 66'(ddx_mag);
                arith_b = 34'(ddx_mag);
            end
            pes_pkg::STEP_DY2:
            begin
                arith_a = 66'(ddy_mag);
                arith_b = 34'(ddy_mag);
            end
            pes_pkg::STEP_LEN:
            begin
                arith_op = pes_pkg::OP_SQRT;
                arith_a  = 66'(sum_reg) << 14;
            end
            pes_pkg::STEP_UX:
            begin
                arith_op = pes_pkg::OP_DIV;
                // rounding: add half the scaled length before dividing
                arith_a  = (66'(ddx_mag) << (DIR_FRAC_BITS + 7)) + 66'(len_reg >> 1);
                arith_b  = len_reg;
            end
            pes_pkg::STEP_UY:
            begin
                arith_op = pes_pkg::OP_DIV;
                arith_a  = (66'(ddy_mag) << (DIR_FRAC_BITS + 7)) + 66'(len_reg >> 1);
                arith_b  = len_reg;
            end
            default:
            begin
                arith_op = pes_pkg::OP_MUL;
            end
        endcase
    end

    pes_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (cmd.go),
        .op     (arith_op),
        .a      (arith_a),
        .b      (arith_b),
        .busy   (arith_busy),
        .done   (arith_done),
        .result (arith_res)
    );

    assign rawq = $signed({1'b0, arith_res[40:0]});
    assign dm   = $signed({1'b0, arith_res[46:16]});
    assign bm   = $signed({2'b00, arith_res[60:16]});
    assign nvx  = 47'(vx_reg) + (diffx[42] ? -bm : bm);
    assign nvy  = 47'(vy_reg) + (diffy[42] ? -bm : bm);
    assign pm   = $signed({2'b00, arith_res[48:16]});
    assign npx  = 35'(tx_reg) + (vx_reg[31] ? -pm : pm);
    assign npy  = 35'(ty_reg) + (vy_reg[31] ? -pm : pm);
    assign uq   = arith_res[15:0];

    // register, history and smoothed velocity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evade_reg     <= 1'b0;
            hist_reg      <= 1'b0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            vx_reg        <= '0;
            vy_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                evade_reg <= cfg_wdata;
            if (arith_done)
            begin
                unique case (cmd.step)
                    pes_pkg::STEP_DECX: vx_reg <= vx_reg[31] ? -dm : dm;
                    pes_pkg::STEP_DECY: vy_reg <= vy_reg[31] ? -dm : dm;
                    pes_pkg::STEP_BLX:  vx_reg <= sat32(nvx);
                    pes_pkg::STEP_BLY:  vy_reg <= sat32(nvy);
                    default:            vx_reg <= vx_reg;
                endcase
            end
            if (cmd.publish)
            begin
                hist_reg      <= 1'b1;
                last_x_reg    <= tx_reg;
                last_y_reg    <= ty_reg;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dt_reg     <= req.delta_t;
            tx_reg     <= req.target_x;
            ty_reg     <= req.target_y;
            ax_reg     <= req.agent_x;
            ay_reg     <= req.agent_y;
            spd_reg    <= req.agent_speed;
            rawx_reg   <= '0;
            rawy_reg   <= '0;
            t_reg      <= '0;
            px_reg     <= '0;
            py_reg     <= '0;
            dirx_reg   <= '0;
            diry_reg   <= '0;
            primed_reg <= hist_reg;
        end
        else if (arith_done)
        begin
            unique case (cmd.step)
                pes_pkg::STEP_RAWX: rawx_reg <= mx[24] ? -rawq : rawq;
                pes_pkg::STEP_RAWY: rawy_reg <= my[24] ? -rawq : rawq;
                pes_pkg::STEP_SQX:  sum_reg  <= arith_res[49:0];
                pes_pkg::STEP_SQY:  sum_reg  <= sum_reg + arith_res[49:0];
                pes_pkg::STEP_DIST: dist_reg <= arith_res[25:0];
                pes_pkg::STEP_TDIV:
                    t_reg <= (arith_res[41:0] > 42'(cap)) ? cap : arith_res[17:0];
                pes_pkg::STEP_PX:   px_reg   <= sat24(npx);
                pes_pkg::STEP_PY:   py_reg   <= sat24(npy);
                pes_pkg::STEP_DX2:  sum_reg  <= arith_res[49:0];
                pes_pkg::STEP_DY2:  sum_reg  <= sum_reg + arith_res[49:0];
                pes_pkg::STEP_LEN:  len_reg  <= arith_res[33:0];
                pes_pkg::STEP_UX:   dirx_reg <= ddx[24] ? 16'(-uq) : uq;
                pes_pkg::STEP_UY:   diry_reg <= ddy[24] ? 16'(-uq) : uq;
                default:            sum_reg  <= sum_reg;
            endcase
        end
        if (cmd.publish)
        begin
            o_dirx_reg   <= dirx_reg;
            o_diry_reg   <= diry_reg;
            o_px_reg     <= px_reg;
            o_py_reg     <= py_reg;
            o_primed_reg <= primed_reg;
        end
    end

    assign req.ready       = cmd.take;
    assign rsp.valid       = out_valid_reg;
    assign rsp.dir_x       = $signed(o_dirx_reg);
    assign rsp.dir_y       = $signed(o_diry_reg);
    assign rsp.predicted_x = o_px_reg;
    assign rsp.predicted_y = o_py_reg;
    assign rsp.primed      = o_primed_reg;

    assign sts.in_valid  = req.valid;
    assign sts.hist      = hist_reg;
    assign sts.dt_ok     = dt_reg > pes_pkg::DT_MIN_EXCL;
    assign sts.near_zero = (rawx_mag <= pes_pkg::NEAR_ZERO_Q8)
                        && (rawy_mag <= pes_pkg::NEAR_ZERO_Q8);
    assign sts.speed_ok  = spd_reg > pes_pkg::SPEED_MIN_EXCL;
    assign sts.sum_zero  = sum_reg == 50'd0;
    assign sts.out_free  = !out_valid_reg || rsp.ready;
    assign sts.done      = arith_done;

`include "pursuit_evade_steering_unit_assert.svh"
    `PES_ASSERT_IMP(a_go_when_idle, cmd.go, !arith_busy)
    `PES_ASSERT_IMP(a_publish_free, cmd.publish, !out_valid_reg || rsp.ready)
    `PES_ASSERT_NXT(a_done_pulse, arith_done, !arith_done)
endmodule
`default_nettype wire

// ----- sv/pes_ctrl.sv -----
// steering sequencer: walks the datapath through one word's steps
`default_nettype none
module pes_ctrl (
    input  wire             clk,
    input  wire             rst_n,
    input  pes_pkg::sts_t   sts,
    output pes_pkg::cmd_t   cmd
);
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_START = 5'd1;
    localparam logic [4:0] S_RAWX  = 5'd2;
    localparam logic [4:0] S_RAWY  = 5'd3;
    localparam logic [4:0] S_VX    = 5'd4;
    localparam logic [4:0] S_VY    = 5'd5;
    localparam logic [4:0] S_SQX   = 5'd6;
    localparam logic [4:0] S_SQY   = 5'd7;
    localparam logic [4:0] S_DIST  = 5'd8;
    localparam logic [4:0] S_TDIV  = 5'd9;
    localparam logic [4:0] S_PX    = 5'd10;
    localparam logic [4:0] S_PY    = 5'd11;
    localparam logic [4:0] S_DX2   = 5'd12;
    localparam logic [4:0] S_DY2   = 5'd13;
    localparam logic [4:0] S_LEN   = 5'd14;
    localparam logic [4:0] S_UX    = 5'd15;
    localparam logic [4:0] S_UY    = 5'd16;
    localparam logic [4:0] S_DONE  = 5'd17;

    logic [4:0] state_reg, state_next;
    logic       wait_reg, wait_next;
    logic [4:0] after;

    // successor of each arithmetic step
    always_comb
    begin
        unique case (state_reg)
            S_RAWX:  after = S_RAWY;
            S_RAWY:  after = S_VX;
            S_VX:    after = S_VY;
            S_VY:    after = sts.speed_ok ? S_SQX : S_PX;
            S_SQX:   after = S_SQY;
            S_SQY:   after = S_DIST;
            S_DIST:  after = S_TDIV;
            S_TDIV:  after = S_PX;
            S_PX:    after = S_PY;
            S_PY:    after = S_DX2;
            S_DX2:   after = S_DY2;
            S_DY2:   after = S_LEN;
            S_LEN:   after = S_UX;
            S_UX:    after = S_UY;
            S_UY:    after = S_DONE;
            default: after = S_IDLE;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        wait_next   = wait_reg;
        cmd.take    = 1'b0;
        cmd.go      = 1'b0;
        cmd.publish = 1'b0;
        unique case (state_reg)
            S_RAWX:  cmd.step = pes_pkg::STEP_RAWX;
            S_RAWY:  cmd.step = pes_pkg::STEP_RAWY;
            S_VX:    cmd.step = sts.near_zero ? pes_pkg::STEP_DECX : pes_pkg::STEP_BLX;
            S_VY:    cmd.step = sts.near_zero ? pes_pkg::STEP_DECY : pes_pkg::STEP_BLY;
            S_SQX:   cmd.step = pes_pkg::STEP_SQX;
            S_SQY:   cmd.step = pes_pkg::STEP_SQY;
            S_DIST:  cmd.step = pes_pkg::STEP_DIST;
            S_TDIV:  cmd.step = pes_pkg::STEP_TDIV;
            S_PX:    cmd.step = pes_pkg::STEP_PX;
            S_PY:    cmd.step = pes_pkg::STEP_PY;
            S_DX2:   cmd.step = pes_pkg::STEP_DX2;
            S_DY2:   cmd.step = pes_pkg::STEP_DY2;
            S_LEN:   cmd.step = pes_pkg::STEP_LEN;
            S_UX:    cmd.step = pes_pkg::STEP_UX;
            S_UY:    cmd.step = pes_pkg::STEP_UY;
            default: cmd.step = pes_pkg::STEP_NONE;
        endcase

        unique case (state_reg)
            S_IDLE:
            begin
                cmd.take = 1'b1;
                if (sts.in_valid)
                    state_next = S_START;
            end
            S_START:
            begin
                // first word only stores the target
                if (!sts.hist)
                    state_next = S_DONE;
                else if (sts.dt_ok)
                    state_next = S_RAWX;
                else
                    state_next = S_VX;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                if (!wait_reg)
                begin
                    // zero-length direction leaves dir at zero
                    if (state_reg == S_LEN && sts.sum_zero)
                        state_next = S_DONE;
                    else
                    begin
                        cmd.go    = 1'b1;
                        wait_next = 1'b1;
                    end
                end
                else if (sts.done)
                begin
                    wait_next  = 1'b0;
                    state_next = after;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wait_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
        end
    end

`include "pursuit_evade_steering_unit_assert.svh"
    `PES_ASSERT_NXT(a_take_starts, cmd.take && sts.in_valid, state_reg == S_START)
    `PES_ASSERT_IMP(a_wait_in_step, wait_reg, state_reg != S_IDLE && state_reg != S_START && state_reg != S_DONE)
    `PES_ASSERT_IMP(a_go_not_waiting, cmd.go, !wait_reg)
endmodule
`default_nettype wire

// ----- sv/pursuit_evade_steering_unit.sv -----
// Pursuit / evade steering unit, top level.
// req: one word per tick (delta_t, target and agent positions, agent speed),
//   taken at a clock edge with req.valid and req.ready high.
// rsp: one word per accepted req word (dir_x/y, predicted_x/y, primed).
// cfg_we / cfg_wdata write evade_mode; write only while the unit is idle.
// One word is worked on at a time; req.ready is high only between words.
// The first word after reset only stores the target and answers with zeros.
// Later words run through one shared bit-serial unit: five divides, eight
// multiplies and two square roots; a slow agent skips the distance and time
// steps, a tiny time step the raw velocity divides and a zero-length
// direction the length and unit-vector steps.
// req.ready rises again in the same cycle as rsp.valid.
// The result sits in an output register; while rsp.ready is low the unit
// still takes and works on the next word and holds it until the register frees.
// Reset clears history, smoothed velocity, evade_mode and rsp.valid.
`default_nettype none
module pursuit_evade_steering_unit #(
    parameter int DIR_FRAC_BITS = 14
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire         cfg_wdata,
    pes_in_if.sink      req,
    pes_out_if.source   rsp
);
    pes_pkg::cmd_t cmd;
    pes_pkg::sts_t sts;

    pes_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    pes_dpath #(
        .DIR_FRAC_BITS (DIR_FRAC_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp),
        .cmd       (cmd),
        .sts       (sts)
    );
endmodule
`default_nettype wire

// ----- test/pes_checker.sv -----
// checker for the steering unit: predicts each result word and compares it
`timescale 1ns / 1ps
`default_nettype none
module pes_checker #(
    parameter int DIR_FRAC_BITS = 14
) (
    input  wire  clk,
    input  wire  rst_n,
    input  wire  cfg_we,
    input  wire  cfg_wdata,
    pes_in_if    req,
    pes_out_if   rsp,
    output int   fail_count,
    output int   pending
);
    typedef struct {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [23:0] pred_x;
        logic signed [23:0] pred_y;
        logic               primed;
    } steer_t;

    steer_t             steer_q[$];
    logic               evade;
    logic signed [23:0] last_x, last_y;
    logic signed [31:0] vel_x, vel_y;
    logic               hist;

    assign pending = steer_q.size();

    function automatic logic [63:0] mag(input longint v);
        mag = (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint signed_of(input logic [63:0] m, input bit neg);
        signed_of = neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint mul_trunc(input longint a, input logic [63:0] b, input int s);
        mul_trunc = signed_of((mag(a) * b) >> s, a < 0);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        int_sqrt = r;
    endfunction

    function automatic logic signed [31:0] next_vel(input longint v, input longint raw,
                                                    input bit nz, input logic [63:0] w);
        longint nv;
        if (nz)
            nv = mul_trunc(v, 64'(pes_pkg::DECAY_Q16), 16);
        else
            nv = v + mul_trunc(raw - v, w, 16);
        if (nv > 64'sd2147483647)
            nv = 64'sd2147483647;
        else if (nv < -64'sd2147483648)
            nv = -64'sd2147483648;
        next_vel = 32'(nv);
    endfunction

    function automatic longint sat_pos(input longint v);
        sat_pos = (v > 8388607) ? 8388607 : ((v < -8388608) ? -8388608 : v);
    endfunction

    task automatic predict_steer(input logic [15:0] dt, input logic signed [23:0] tx,
                                 input logic signed [23:0] ty, input logic signed [23:0] ax,
                                 input logic signed [23:0] ay, input logic [21:0] spd,
                                 output steer_t r);
        longint      rx, ry, mx, my, px, py, dx, dy;
        logic [63:0] t, cap, sum, len, num;
        bit          nz;
        r = '{default: '0};
        if (!hist)
        begin
            last_x = tx;
            last_y = ty;
            hist = 1'b1;
            return;
        end
        rx = 0;
        ry = 0;
        if (dt > pes_pkg::DT_MIN_EXCL)
        begin
            mx = longint'(tx) - longint'(last_x);
            my = longint'(ty) - longint'(last_y);
            rx = signed_of((mag(mx) << 16) / dt, mx < 0);
            ry = signed_of((mag(my) << 16) / dt, my < 0);
        end
        nz = mag(rx) <= 256 && mag(ry) <= 256;
        vel_x = next_vel(vel_x, rx, nz, 64'(dt) * 10);
        vel_y = next_vel(vel_y, ry, nz, 64'(dt) * 10);
        last_x = tx;
        last_y = ty;
        dx = longint'(tx) - longint'(ax);
        dy = longint'(ty) - longint'(ay);
        t = 0;
        if (spd > pes_pkg::SPEED_MIN_EXCL)
            t = (int_sqrt(mag(dx) * mag(dx) + mag(dy) * mag(dy)) << 16) / spd;
        cap = evade ? 64'(pes_pkg::CAP_EVADE_Q16) : 64'(pes_pkg::CAP_PURSUIT_Q16);
        if (t > cap)
            t = cap;
        px = sat_pos(longint'(tx) + mul_trunc(vel_x, t, 16));
        py = sat_pos(longint'(ty) + mul_trunc(vel_y, t, 16));
        if (evade)
        begin
            dx = longint'(ax) - px;
            dy = longint'(ay) - py;
        end
        else
        begin
            dx = px - longint'(ax);
            dy = py - longint'(ay);
        end
        sum = mag(dx) * mag(dx) + mag(dy) * mag(dy);
        if (sum != 0)
        begin
            len = int_sqrt(sum << 14);
            num = mag(dx) << (DIR_FRAC_BITS + 7);
            r.dir_x = 16'(signed_of((num + (len >> 1)) / len, dx < 0));
            num = mag(dy) << (DIR_FRAC_BITS + 7);
            r.dir_y = 16'(signed_of((num + (len >> 1)) / len, dy < 0));
        end
        r.pred_x = 24'(px);
        r.pred_y = 24'(py);
        r.primed = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        steer_t e, got;
        if (!rst_n)
        begin
            evade = 1'b0;
            last_x = '0;
            last_y = '0;
            vel_x = '0;
            vel_y = '0;
            hist = 1'b0;
            fail_count = 0;
            steer_q.delete();
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                predict_steer(req.delta_t, req.target_x, req.target_y, req.agent_x,
                              req.agent_y, req.agent_speed, e);
                steer_q.push_back(e);
            end
            if (rsp.valid && rsp.ready)
            begin
                got = '{rsp.dir_x, rsp.dir_y, rsp.predicted_x, rsp.predicted_y, rsp.primed};
                if (steer_q.size() == 0)
                begin
                    $error("unexpected result word");
                    fail_count++;
                end
                else
                begin
                    e = steer_q.pop_front();
                    if (got.dir_x !== e.dir_x)
                    begin
                        $error("dir_x: expected %0d, actual %0d", e.dir_x, got.dir_x);
                        fail_count++;
                    end
                    if (got.dir_y !== e.dir_y)
                    begin
                        $error("dir_y: expected %0d, actual %0d", e.dir_y, got.dir_y);
                        fail_count++;
                    end
                    if (got.pred_x !== e.pred_x)
                    begin
                        $error("predicted_x: expected %0d, actual %0d", e.pred_x, got.pred_x);
                        fail_count++;
                    end
                    if (got.pred_y !== e.pred_y)
                    begin
                        $error("predicted_y: expected %0d, actual %0d", e.pred_y, got.pred_y);
                        fail_count++;
                    end
                    if (got.primed !== e.primed)
                    begin
                        $error("primed: expected %0d, actual %0d", e.primed, got.primed);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
                evade = cfg_wdata;
        end
    end
endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// stimulus and verdict for the steering unit
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    typedef struct {
        logic        [15:0] dt;
        logic signed [23:0] tx, ty, ax, ay;
        logic        [21:0] spd;
    } tick_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;
    int   fail_count;
    int   pending;
    int   burst_left = 0;
    int   tgt_x = 0, tgt_y = 0;
    int   cyc = 0;

    pes_in_if  in_if ();
    pes_out_if out_if ();

    pursuit_evade_steering_unit dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .req(in_if), .rsp(out_if)
    );

    pes_checker chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .req(in_if), .rsp(out_if), .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        in_if.valid = 1'b0;
        in_if.delta_t = '0;
        in_if.target_x = '0;
        in_if.target_y = '0;
        in_if.agent_x = '0;
        in_if.agent_y = '0;
        in_if.agent_speed = '0;
        out_if.ready = 1'b0;
    end

    // receiver: stretches of steady ready alternate with random stalls
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if ((cyc / 3000) % 3 == 0)
            out_if.ready <= 1'b1;
        else
            out_if.ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic send_tick(input tick_t w);
        if (burst_left == 0)
        begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 6);
        end
        in_if.valid <= 1'b1;
        in_if.delta_t <= w.dt;
        in_if.target_x <= w.tx;
        in_if.target_y <= w.ty;
        in_if.agent_x <= w.ax;
        in_if.agent_y <= w.ay;
        in_if.agent_speed <= w.spd;
        do
            @(posedge clk);
        while (!in_if.ready);
        burst_left--;
    endtask

    // drain all results, then leave room for the unit to settle before a write
    task automatic set_mode(input logic m);
        in_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic tick_t mk(input int dt, input int tx, input int ty, input int ax,
                                 input int ay, input int spd);
        tick_t w;
        w.dt = 16'(dt);
        w.tx = 24'(tx);
        w.ty = 24'(ty);
        w.ax = 24'(ax);
        w.ay = 24'(ay);
        w.spd = 22'(spd);
        return w;
    endfunction

    function automatic tick_t rand_tick();
        tick_t w;
        int    k;
        k = $urandom_range(0, 99);
        if (k < 12)
        begin
            w.dt = 16'($urandom);
            w.tx = 24'($urandom);
            w.ty = 24'($urandom);
            w.ax = 24'($urandom);
            w.ay = 24'($urandom);
            w.spd = 22'($urandom);
            return w;
        end
        // smooth target track, sometimes standing still or with a tiny step
        if (k >= 22)
        begin
            tgt_x += $urandom_range(0, 4000) - 2000;
            tgt_y += $urandom_range(0, 4000) - 2000;
        end
        if (tgt_x > 4000000 || tgt_x < -4000000)
            tgt_x = 0;
        if (tgt_y > 4000000 || tgt_y < -4000000)
            tgt_y = 0;
        w.dt = (k < 16) ? 16'($urandom_range(0, 8)) : 16'($urandom_range(100, 4000));
        w.tx = 24'(tgt_x);
        w.ty = 24'(tgt_y);
        w.ax = 24'(tgt_x + $urandom_range(0, 100000) - 50000);
        w.ay = 24'(tgt_y + $urandom_range(0, 100000) - 50000);
        w.spd = (k < 19) ? 22'($urandom_range(0, 300)) : 22'($urandom_range(257, 40000));
        return w;
    endfunction

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_mode(1'b0);
        // first tick, then time step and speed thresholds
        send_tick(mk(1000, 0, 0, 5000, 5000, 2000));
        send_tick(mk(0, 100, 100, 0, 0, 1000));
        send_tick(mk(6, 400, 400, 0, 0, 256));
        send_tick(mk(7, 4000, 4000, 0, 0, 257));
        send_tick(mk(65535, 8388607, 8388607, -8388608, -8388608, 4194303));
        send_tick(mk(65535, -8388608, -8388608, 8388607, 8388607, 4194303));
        send_tick(mk(1, -8388608, 8388607, 0, 0, 0));
        send_tick(mk(300, 8388607, -8388608, 8388607, -8388608, 300));
        // near-zero move decays the smoothed velocity
        send_tick(mk(6553, 8388607, -8388608, 0, 0, 512));
        send_tick(mk(6553, 8388607, -8388608, 0, 0, 512));
        // zero-length direction: slow agent sitting on the target
        send_tick(mk(6553, 1234, -567, 1234, -567, 0));
        send_tick(mk(200, 30000, 30000, -30000, 0, 1));
        send_tick(mk(200, 60000, 60000, 0, 0, 4194303));
        set_mode(1'b1);
        send_tick(mk(200, 90000, 90000, 0, 0, 300));
        send_tick(mk(200, 120000, 90000, -100000, 5, 257));
        send_tick(mk(65535, -8388608, 8388607, 8388607, -8388608, 256));
        send_tick(mk(500, -8388000, 8388000, -8388000, 8388000, 0));
        send_tick(mk(500, 0, 0, 0, 0, 4194303));
        for (int ph = 0; ph < 7; ph++)
        begin
            set_mode(ph % 2 == 1);
            repeat (250) send_tick(rand_tick());
        end
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire
